// ----- design/adc_avg_pkg.sv -----
// Package: shared constants and codes for the ADC block averager.
`default_nettype none
package adc_avg_pkg;

    localparam int SAMPLE_BITS     = 10;
    localparam int MAX_RUN_DEFAULT = 64;
    localparam int TOP_CHANNEL     = 7;

    localparam int COUNT_BITS   = 8;
    localparam int CHANNEL_BITS = 4;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    localparam logic [COUNT_BITS-1:0]   COUNT_RESET   = 8'd16;
    localparam logic [CHANNEL_BITS-1:0] CHANNEL_RESET = 4'd0;

    // register index, taken from paddr[2]
    localparam logic REG_SAMPLE_COUNT   = 1'b0;
    localparam logic REG_CHANNEL_SELECT = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK          = 2'd0;
    localparam status_t STATUS_BAD_CHANNEL = 2'd1;
    localparam status_t STATUS_BAD_COUNT   = 2'd2;

endpackage
`default_nettype wire

// ----- design/adc_block_averager_top.sv -----
// ADC block averager: run accumulation plus a shared bit-serial divider.
//
// Usage: raw converter samples enter on the s_ channel (valid/ready), one
// word each. The first sample of a run is a settling sample and is dropped;
// the next sample_count samples are summed, then the truncated mean leaves
// on the m_ channel with status OK. Channel and count are checked on the
// settling sample; a bad channel (status 1) or a count of 0 or above
// MAX_RUN (status 2) gives one result word with average 0 and no run.
// Registers sit on an APB-style port: sample_count at 0x0, channel_select
// at 0x4; a run latches the count when it starts.
// Timing: after the last sample of a run the restoring divider produces
// one quotient bit per cycle, and the result then goes to the output
// register; check errors appear the cycle after the settling sample.
// s_ready is low while dividing.
// The result sits in an output register; while the receiver stalls with a
// word held, s_ready stays low and no new sample is taken.
// Reset (aresetn low, synchronous) drops any run in progress, clears the
// output valid and restores sample_count 16 and channel_select 0.
`default_nettype none
module adc_block_averager_top
    import adc_avg_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_BITS-1:0]   paddr,
    input  wire logic [DATA_BITS-1:0]   pwdata,
    output logic      [DATA_BITS-1:0]   prdata,
    output logic                        pready,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_raw_sample,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [SAMPLE_BITS-1:0] m_average,
    output logic      [1:0]             m_status
);

    localparam int CNT_W  = $clog2(MAX_RUN + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int ITER_W = $clog2(SAMPLE_BITS);

    localparam logic [COUNT_BITS-1:0]   MAX_COUNT   = COUNT_BITS'(MAX_RUN);
    localparam logic [CHANNEL_BITS-1:0] TOP_CHAN    = CHANNEL_BITS'(TOP_CHANNEL);
    localparam logic [ITER_W-1:0]       ITER_LAST   = ITER_W'(SAMPLE_BITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [COUNT_BITS-1:0]   sample_count_reg;
    logic [CHANNEL_BITS-1:0] channel_select_reg;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       run_len_reg, run_len_next;
    logic [CNT_W-1:0]       taken_reg, taken_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;

    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_average_reg, m_average_next;
    status_t                m_status_reg, m_status_next;

    logic                   reg_idx;
    logic                   cfg_write;
    logic                   out_free;
    logic                   s_take;
    logic [SUM_W-1:0]       sum_add;
    logic [CNT_W-1:0]       taken_inc;
    logic [CNT_W:0]         trial;
    logic                   trial_ge;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg   <= COUNT_RESET;
            channel_select_reg <= CHANNEL_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SAMPLE_COUNT:   sample_count_reg   <= pwdata[COUNT_BITS-1:0];
                REG_CHANNEL_SELECT: channel_select_reg <= pwdata[CHANNEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SAMPLE_COUNT:   prdata = DATA_BITS'(sample_count_reg);
            REG_CHANNEL_SELECT: prdata = DATA_BITS'(channel_select_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- datapath and sequencer ----------------
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE || state_reg == ST_RUN) && out_free;
    assign s_take    = s_valid && s_ready;
    assign sum_add   = sum_reg + SUM_W'(s_raw_sample);
    assign taken_inc = taken_reg + 1'b1;

    // shared restoring-divide step: bring down one dividend bit, trial subtract
    assign trial    = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign trial_ge = trial >= {1'b0, run_len_reg};

    always_comb begin
        state_next     = state_reg;
        run_len_next   = run_len_reg;
        taken_next     = taken_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_average_next = m_average_reg;
        m_status_next  = m_status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    if (channel_select_reg > TOP_CHAN) begin
                        m_valid_next   = 1'b1;
                        m_average_next = '0;
                        m_status_next  = STATUS_BAD_CHANNEL;
                    end else if (sample_count_reg == '0 || sample_count_reg > MAX_COUNT) begin
                        m_valid_next   = 1'b1;
                        m_average_next = '0;
                        m_status_next  = STATUS_BAD_COUNT;
                    end else begin
                        // settling sample dropped, run opens
                        run_len_next = sample_count_reg[CNT_W-1:0];
                        taken_next   = '0;
                        sum_next     = '0;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (s_take) begin
                    sum_next   = sum_add;
                    taken_next = taken_inc;
                    if (taken_inc >= run_len_reg) begin
                        // quotient fits SAMPLE_BITS, so the top part is already below the divisor
                        rem_next   = sum_add[SUM_W-1:SAMPLE_BITS];
                        quo_next   = sum_add[SAMPLE_BITS-1:0];
                        iter_next  = ITER_LAST;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = trial_ge ? CNT_W'(trial - {1'b0, run_len_reg}) : trial[CNT_W-1:0];
                quo_next  = {quo_reg[SAMPLE_BITS-2:0], trial_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_average_next = quo_reg;
                    m_status_next  = STATUS_OK;
                    taken_next     = '0;
                    sum_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            taken_reg   <= '0;
            sum_reg     <= '0;
            run_len_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            taken_reg   <= taken_next;
            sum_reg     <= sum_next;
            run_len_reg <= run_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        iter_reg      <= iter_next;
        m_average_reg <= m_average_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;
    assign m_status  = m_status_reg;

endmodule
`default_nettype wire
